[design/assert_macros.svh]
// Assertion macros shared by the tower centroid event plane RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCEP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define TCEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/tcep_pkg.sv]
// Package for the tower centroid event plane: payload types, widths, status codes
// and the CORDIC arctangent table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcep_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STEPS  = 32;
    localparam int EW    = 16;                 // tower energy width
    localparam int SUMW  = 17;                 // side energy sum
    localparam int Q4W   = 21;                 // 4*q, signed
    localparam int QW    = 16;                 // quotient bits of the normalized vector
    localparam int REMW  = 33;                 // divider partial remainder
    localparam int DENW  = 18;                 // divider denominator (2*sum)
    localparam int CW    = 54;                 // CORDIC x and y
    localparam int ZW    = 34;                 // CORDIC angle accumulator
    localparam int OW    = 24;                 // vector output width
    localparam int ASH   = 32 - ANGLE_BITS;    // angle rounding shift

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TOWER = 2'd1,
        ST_SUM   = 2'd2
    } t_status;

    typedef enum logic {
        REG_NORMALIZE = 1'b0,
        REG_MIN_SUM   = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic signed [EW-1:0] a_tower_0;
        logic signed [EW-1:0] a_tower_1;
        logic signed [EW-1:0] a_tower_2;
        logic signed [EW-1:0] a_tower_3;
        logic signed [EW-1:0] c_tower_0;
        logic signed [EW-1:0] c_tower_1;
        logic signed [EW-1:0] c_tower_2;
        logic signed [EW-1:0] c_tower_3;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0]         qx_a;
        logic signed [OW-1:0]         qy_a;
        logic signed [OW-1:0]         qx_c;
        logic signed [OW-1:0]         qy_c;
        logic signed [ANGLE_BITS-1:0] angle_a;
        logic signed [ANGLE_BITS-1:0] angle_c;
        t_status                      status;
    } t_out;

    // Lanes 0..3 are qx_a, qy_a, qx_c, qy_c; side 0 is A and side 1 is C.
    typedef struct packed {
        t_status                    status;
        logic                       norm;
        logic [1:0]                 zero;
        logic [1:0][CW-1:0]         x;
        logic [1:0][CW-1:0]         y;
        logic [1:0][ZW-1:0]         z;
        logic [3:0][REMW-1:0]       rem;
        logic [1:0][DENW-1:0]       den;
        logic [3:0][QW-1:0]         quo;
        logic [3:0]                 neg;
        logic [3:0][Q4W-1:0]        q4;
    } t_stage;

    // atan(2^-i) with pi = 2^31.
    function automatic logic [ZW-1:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return ZW'(v);
    endfunction

endpackage

`default_nettype wire

[design/tcep_front.sv]
// Input stage of the tower centroid event plane: tower checks, side sums,
// 4*q vectors, divider and CORDIC set-up. Depends on tcep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcep_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_vld,
    input  wire tcep_pkg::t_in              i_in,
    input  wire logic                       i_normalize,
    input  wire logic [tcep_pkg::SUMW-1:0]  i_min_sum,
    output logic                            o_vld,
    output tcep_pkg::t_stage                o_stage
);

    localparam int Q4W  = tcep_pkg::Q4W;
    localparam int CW   = tcep_pkg::CW;
    localparam int ZW   = tcep_pkg::ZW;
    localparam int REMW = tcep_pkg::REMW;
    localparam int DENW = tcep_pkg::DENW;
    localparam int SUMW = tcep_pkg::SUMW;

    logic                  r_vld;
    tcep_pkg::t_stage      r_stage;
    tcep_pkg::t_stage      n_stage;

    always_comb begin
        logic signed [tcep_pkg::EW-1:0] e [8];
        logic                           bad;
        logic [SUMW-1:0]                sum [2];
        logic signed [Q4W-1:0]          dx, dy, qx4, qy4, mag;
        logic signed [CW-1:0]           xs, ys;

        e[0] = i_in.a_tower_0;  e[1] = i_in.a_tower_1;
        e[2] = i_in.a_tower_2;  e[3] = i_in.a_tower_3;
        e[4] = i_in.c_tower_0;  e[5] = i_in.c_tower_1;
        e[6] = i_in.c_tower_2;  e[7] = i_in.c_tower_3;
        bad = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (e[k][tcep_pkg::EW-1] || e[k] == '0) begin
                bad = 1'b1;
            end
        end
        n_stage = '0;
        n_stage.norm = i_normalize;
        for (int s = 0; s < 2; s++) begin
            // Towers are positive here whenever the event is kept, so the
            // low bits of each energy suffice for the sum.
            sum[s] = SUMW'(e[4*s][tcep_pkg::EW-2:0]) + SUMW'(e[4*s+1][tcep_pkg::EW-2:0])
                   + SUMW'(e[4*s+2][tcep_pkg::EW-2:0]) + SUMW'(e[4*s+3][tcep_pkg::EW-2:0]);
            dx = -Q4W'(e[4*s]) + Q4W'(e[4*s+1]) - Q4W'(e[4*s+2]) + Q4W'(e[4*s+3]);
            dy = -Q4W'(e[4*s]) - Q4W'(e[4*s+1]) + Q4W'(e[4*s+2]) + Q4W'(e[4*s+3]);
            qx4 = (dx <<< 3) - dx;
            qy4 = (dy <<< 3) - dy;
            n_stage.q4[2*s]   = qx4;
            n_stage.q4[2*s+1] = qy4;
            n_stage.den[s]    = DENW'({sum[s], 1'b0});
            for (int j = 0; j < 2; j++) begin
                mag = (j == 0) ? qx4 : qy4;
                n_stage.neg[2*s+j] = mag[Q4W-1];
                if (mag[Q4W-1]) begin
                    mag = -mag;
                end
                // Rounded quotient is floor((2^(F-1)*|q4| + sum) / (2*sum)).
                n_stage.rem[2*s+j] = (REMW'(mag) << (tcep_pkg::FRACTION_BITS - 1))
                                   + REMW'(sum[s]);
            end
            n_stage.zero[s] = (qx4 == '0) && (qy4 == '0);
            xs = CW'(qx4) <<< 30;
            ys = CW'(qy4) <<< 30;
            if (xs[CW-1]) begin
                n_stage.z[s] = ys[CW-1] ? -(ZW'(1) << 31) : (ZW'(1) << 31);
                xs = -xs;
                ys = -ys;
            end
            n_stage.x[s] = xs;
            n_stage.y[s] = ys;
        end
        if (bad) begin
            n_stage.status = tcep_pkg::ST_TOWER;
        end else if (sum[0] <= i_min_sum || sum[1] <= i_min_sum) begin
            n_stage.status = tcep_pkg::ST_SUM;
        end else begin
            n_stage.status = tcep_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

[design/tcep_cell.sv]
// One cell of the centroid chain: a CORDIC vectoring step for both sides and,
// in the first cells, one restoring-divider bit for all four lanes. Depends on tcep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcep_cell #(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire tcep_pkg::t_stage  i_stage,
    output logic                   o_vld,
    output tcep_pkg::t_stage       o_stage
);

    localparam int CW   = tcep_pkg::CW;
    localparam int QW   = tcep_pkg::QW;
    localparam int REMW = tcep_pkg::REMW;
    // Quotient bit this cell decides; cells past the divider never use it.
    localparam int QB   = (IDX < QW) ? (QW - 1 - IDX) : 0;

    logic              r_vld;
    tcep_pkg::t_stage  r_stage;
    tcep_pkg::t_stage  n_stage;

    always_comb begin
        logic signed [CW-1:0] x, y, dx, dy;
        logic [REMW:0]        sh;

        n_stage = i_stage;
        for (int s = 0; s < 2; s++) begin
            x  = i_stage.x[s];
            y  = i_stage.y[s];
            dx = y >>> IDX;
            dy = x >>> IDX;
            if (!y[CW-1]) begin
                n_stage.x[s] = x + dx;
                n_stage.y[s] = y - dy;
                n_stage.z[s] = i_stage.z[s] + tcep_pkg::atan_val(5'(IDX));
            end else begin
                n_stage.x[s] = x - dx;
                n_stage.y[s] = y + dy;
                n_stage.z[s] = i_stage.z[s] - tcep_pkg::atan_val(5'(IDX));
            end
        end
        for (int l = 0; l < 4; l++) begin
            sh = '0;
            if (IDX < QW) begin
                sh = (REMW+1)'(i_stage.den[l >> 1]) << QB;
                if ({1'b0, i_stage.rem[l]} >= sh) begin
                    n_stage.rem[l] = i_stage.rem[l] - sh[REMW-1:0];
                    n_stage.quo[l][QB] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

[design/tcep_back.sv]
// Output register of the centroid chain: vector selection, angle rounding and
// zeroing of rejected events. Depends on tcep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcep_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire tcep_pkg::t_stage  i_stage,
    output logic                   o_vld,
    output tcep_pkg::t_out         o_out
);

    localparam int OW  = tcep_pkg::OW;
    localparam int ZW  = tcep_pkg::ZW;
    localparam int AB  = tcep_pkg::ANGLE_BITS;
    localparam int ASH = tcep_pkg::ASH;

    logic            r_vld;
    tcep_pkg::t_out  r_out;
    tcep_pkg::t_out  n_out;

    always_comb begin
        logic signed [OW-1:0] v [4];
        logic [ZW-1:0]        zr [2];
        logic [AB-1:0]        ang [2];

        for (int l = 0; l < 4; l++) begin
            if (i_stage.norm) begin
                v[l] = i_stage.neg[l] ? -OW'(i_stage.quo[l]) : OW'(i_stage.quo[l]);
            end else begin
                v[l] = OW'($signed(i_stage.q4[l]));
            end
        end
        for (int s = 0; s < 2; s++) begin
            zr[s]  = i_stage.z[s] + (ZW'(1) << (ASH - 1));
            ang[s] = i_stage.zero[s] ? '0 : zr[s][ASH+AB-1:ASH];
        end
        n_out         = '0;
        n_out.status  = i_stage.status;
        if (i_stage.status == tcep_pkg::ST_OK) begin
            n_out.qx_a    = v[0];
            n_out.qy_a    = v[1];
            n_out.qx_c    = v[2];
            n_out.qy_c    = v[3];
            n_out.angle_a = ang[0];
            n_out.angle_c = ang[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_vld = r_vld;
    assign o_out = r_out;

endmodule

`default_nettype wire

[design/tower_centroid_event_plane.sv]
// Tower centroid event plane top level: APB register file and the cell chain.
// Depends on tcep_pkg, tcep_front, tcep_cell, tcep_back and assert_macros.svh.
//
// Use: one event (four tower energies per side) is a transfer on the input
// channel, accepted when i_in_valid is high and o_in_stall is low. One result
// per event leaves on the output channel, taken when o_out_valid is high and
// i_out_stall is low.
// The chain is one input stage, 32 CORDIC cells (the first 16 also
// produce one quotient bit of each normalized vector) and one output register.
// One event enters per cycle while the receiver does not stall; the chain holds up to 34 events at once.
// The chain advances as a whole; when the output register is full and the
// receiver stalls, every stage holds and o_in_stall is raised in that cycle.
// Reset clears all valid bits, sets normalize to 1 and min_sum to 0.
// Registers: normalize at address 0, min_sum at address 4; write them only
// while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tower_centroid_event_plane (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire tcep_pkg::t_in           i_in,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output tcep_pkg::t_out               o_out,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int STEPS = tcep_pkg::CORDIC_STEPS;
    localparam int SUMW  = tcep_pkg::SUMW;

    logic              r_normalize;
    logic [SUMW-1:0]   r_min_sum;
    logic              w_en;
    logic              w_vld   [STEPS+1];
    tcep_pkg::t_stage  w_stage [STEPS+1];
    tcep_pkg::t_reg_index w_idx;

    assign pready = 1'b1;
    assign w_idx  = tcep_pkg::t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normalize <= 1'b1;
            r_min_sum   <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                tcep_pkg::REG_NORMALIZE: r_normalize <= pwdata[0];
                tcep_pkg::REG_MIN_SUM:   r_min_sum   <= pwdata[SUMW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tcep_pkg::REG_NORMALIZE: prdata = {31'b0, r_normalize};
            tcep_pkg::REG_MIN_SUM:   prdata = {{(32-SUMW){1'b0}}, r_min_sum};
            default:                 prdata = '0;
        endcase
    end

    // The whole chain moves unless a finished result waits on a stalled receiver.
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    tcep_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_in_valid),
        .i_in        (i_in),
        .i_normalize (r_normalize),
        .i_min_sum   (r_min_sum),
        .o_vld       (w_vld[0]),
        .o_stage     (w_stage[0])
    );

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        tcep_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_stage (w_stage[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    tcep_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[STEPS]),
        .i_stage (w_stage[STEPS]),
        .o_vld   (o_out_valid),
        .o_out   (o_out)
    );

    `TCEP_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, o_out_valid && (o_out.status != tcep_pkg::ST_OK), (o_out.qx_a == '0) && (o_out.qy_c == '0) && (o_out.angle_a == '0) && (o_out.angle_c == '0), "rejected event carries nonzero data")
    `TCEP_ASSERT_IMP(a_norm_range, i_clk, i_rst_n, o_out_valid && r_normalize && (o_out.status == tcep_pkg::ST_OK), ($signed(o_out.qx_a) < 24'sd32768) && ($signed(o_out.qx_a) > -24'sd32768), "normalized centroid out of range")
    `TCEP_ASSERT(a_stall_cause, i_clk, i_rst_n, !o_in_stall || o_out_valid, "input stalled with empty output register")

endmodule

`default_nettype wire
